>>> rtl/acf_pkg.sv
package acf_pkg;

    localparam int DATA_W    = 64;
    localparam int SHAMT_W   = 6;
    localparam int KIND_W    = 4;
    localparam int FLAG_W    = 4;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_SADD = 4'd0,
        KIND_UADD = 4'd1,
        KIND_SSUB = 4'd2,
        KIND_USUB = 4'd3,
        KIND_INC  = 4'd4,
        KIND_DEC  = 4'd5,
        KIND_AND  = 4'd6,
        KIND_OR   = 4'd7,
        KIND_XOR  = 4'd8,
        KIND_SAL  = 4'd9,
        KIND_SAR  = 4'd10,
        KIND_SHL  = 4'd11,
        KIND_SHR  = 4'd12
    } kind_t;

    // The zero flag sits in the lowest bit.
    typedef struct packed {
        logic carry;
        logic overflow;
        logic sign;
        logic zero;
    } flags_t;

endpackage

>>> rtl/acf_exec.sv
module acf_exec (
    input  acf_pkg::kind_t                  kind,
    input  logic [acf_pkg::DATA_W-1:0]      operand_a,
    input  logic [acf_pkg::DATA_W-1:0]      operand_b,
    input  logic [acf_pkg::SHAMT_W-1:0]     shift_amount,
    input  acf_pkg::flags_t                 flags_in,
    output logic [acf_pkg::DATA_W-1:0]      value,
    output acf_pkg::flags_t                 flags_out
);
    import acf_pkg::*;

    logic [DATA_W-1:0] addend;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] sum_r;
    logic              sum_ovf;
    logic [DATA_W-1:0] shl_r;
    logic [DATA_W-1:0] sar_r;
    logic [DATA_W-1:0] shr_r;
    logic [DATA_W-1:0] logic_r;

    always_comb begin
        case (kind)
            KIND_SSUB, KIND_USUB: begin
                addend = {DATA_W{1'b0}} - operand_b;
            end
            KIND_INC: begin
                addend = {{(DATA_W-1){1'b0}}, 1'b1};
            end
            KIND_DEC: begin
                addend = {DATA_W{1'b1}};
            end
            default: begin
                addend = operand_b;
            end
        endcase
    end

    assign sum     = {1'b0, operand_a} + {1'b0, addend};
    assign sum_r   = sum[DATA_W-1:0];
    assign sum_ovf = (operand_a[DATA_W-1] == addend[DATA_W-1])
                     && (sum_r[DATA_W-1] != operand_a[DATA_W-1]);

    assign shl_r = operand_a << shift_amount;
    assign sar_r = DATA_W'($signed(operand_a) >>> shift_amount);
    assign shr_r = operand_a >> shift_amount;

    always_comb begin
        case (kind)
            KIND_AND: begin
                logic_r = operand_a & operand_b;
            end
            KIND_OR: begin
                logic_r = operand_a | operand_b;
            end
            KIND_XOR: begin
                logic_r = operand_a ^ operand_b;
            end
            default: begin
                logic_r = sar_r;
            end
        endcase
    end

    always_comb begin
        value     = {DATA_W{1'b0}};
        flags_out = flags_in;
        case (kind)
            KIND_SADD, KIND_SSUB: begin
                value              = sum_r;
                flags_out.zero     = (sum_r == {DATA_W{1'b0}});
                flags_out.sign     = sum_r[DATA_W-1];
                flags_out.overflow = sum_ovf;
            end
            KIND_UADD, KIND_USUB, KIND_INC, KIND_DEC: begin
                value           = sum_r;
                flags_out.zero  = (sum_r == {DATA_W{1'b0}});
                flags_out.carry = sum[DATA_W];
            end
            KIND_AND, KIND_OR, KIND_XOR, KIND_SAR: begin
                value              = logic_r;
                flags_out.zero     = (logic_r == {DATA_W{1'b0}});
                flags_out.sign     = logic_r[DATA_W-1];
                flags_out.overflow = 1'b0;
            end
            KIND_SAL: begin
                value              = shl_r;
                flags_out.zero     = (shl_r == {DATA_W{1'b0}});
                flags_out.sign     = shl_r[DATA_W-1];
                flags_out.overflow = operand_a[DATA_W-1] ^ shl_r[DATA_W-1];
            end
            KIND_SHL: begin
                value           = shl_r;
                flags_out.zero  = (shl_r == {DATA_W{1'b0}});
                flags_out.carry = (shl_r < operand_a);
            end
            KIND_SHR: begin
                value           = shr_r;
                flags_out.zero  = (shr_r == {DATA_W{1'b0}});
                flags_out.carry = 1'b0;
            end
            default: begin
                value     = {DATA_W{1'b0}};
                flags_out = flags_in;
            end
        endcase
    end

endmodule

>>> rtl/alu_with_condition_flags.sv
// A 64-bit ALU with four sticky condition flags (zero, sign, overflow, carry).
// Each request carries one operation and returns one result holding the value
// and all four flags as they stand after that operation; each operation only
// rewrites its own flags. The block takes one request per clock cycle while
// the receiver keeps taking results, and presents its result once the request
// moves from the input register into the result register. The rate is set by the
// combinational execute step between those registers, whose flag update feeds
// straight back into the flag register for the next request. Unused operation
// codes return zero and leave the flags alone.
module alu_with_condition_flags (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // operand_a [63:0], operand_b [127:64], shift_amount [133:128], zero pad
    input  logic [acf_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind [3:0]
    input  logic [acf_pkg::KIND_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // value [63:0]
    output logic [acf_pkg::M_TDATA_W-1:0]    m_tdata,
    // zero_flag [0], sign_flag [1], overflow_flag [2], carry_flag [3]
    output logic [acf_pkg::FLAG_W-1:0]       m_tuser
);
    import acf_pkg::*;

    logic                 in_valid_reg;
    kind_t                kind_reg;
    logic [DATA_W-1:0]    operand_a_reg;
    logic [DATA_W-1:0]    operand_b_reg;
    logic [SHAMT_W-1:0]   shift_amount_reg;
    logic                 out_valid_reg;
    logic [DATA_W-1:0]    value_reg;
    flags_t               result_flags_reg;
    flags_t               flag_reg;
    flags_t               flag_next;
    logic [DATA_W-1:0]    value_next;
    logic                 advance;
    logic                 s_accept;

    acf_exec u_exec (
        .kind         (kind_reg),
        .operand_a    (operand_a_reg),
        .operand_b    (operand_b_reg),
        .shift_amount (shift_amount_reg),
        .flags_in     (flag_reg),
        .value        (value_next),
        .flags_out    (flag_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg         <= kind_t'(s_tuser);
            operand_a_reg    <= s_tdata[DATA_W-1:0];
            operand_b_reg    <= s_tdata[2*DATA_W-1:DATA_W];
            shift_amount_reg <= s_tdata[2*DATA_W+SHAMT_W-1:2*DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                flag_reg      <= flag_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            value_reg        <= value_next;
            result_flags_reg <= flag_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tuser  = result_flags_reg;

    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flag_reg))
        else $error("Flags changed without an operation being executed.");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tvalid && (m_tuser == flag_reg)))
        else $error("Result flags differ from the stored flags.");

    a_unused_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (kind_reg > KIND_SHR)) |=>
            ((m_tdata == {DATA_W{1'b0}}) && $stable(flag_reg)))
        else $error("Unused operation code altered the flags or gave a value.");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready)
        else $error("Input accepted while both stages were full and stalled.");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import acf_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_OPS   = 625;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 100;
    localparam int HOLD_AT      = 150;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 480;
    localparam int DIRECTED_N   = 25;

    // Operation codes the block does not decode.
    localparam logic [KIND_W-1:0] KIND_NONE_LO = 4'd13;
    localparam logic [KIND_W-1:0] KIND_NONE_HI = 4'd15;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [SHAMT_W-1:0] n;
        logic               typed;
        logic [DATA_W-1:0]  value;
        flags_t             flags;
    } op_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        flags_t            flags;
    } alu_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [FLAG_W-1:0]    m_tuser;

    flags_t      cc_flags = '0;
    op_req_t     offered_ops[$];
    alu_result_t pending_results[$];
    int          ops_accepted = 0;
    int          idle_cycles = 0;
    bit          failed = 1'b0;

    // The first rows run straight after reset, so their flags can be read off by hand.
    op_req_t directed_ops [DIRECTED_N] = '{
        '{KIND_SADD, 64'h0, 64'h0, 6'd0, 1'b1, 64'h0, 4'b0001},
        '{KIND_SADD, MOST_POS, 64'h1, 6'd0, 1'b1, MOST_NEG, 4'b0110},
        '{KIND_UADD, ALL_ONES, 64'h1, 6'd0, 1'b1, 64'h0, 4'b1111},
        '{KIND_SSUB, 64'h0, MOST_NEG, 6'd0, 1'b1, MOST_NEG, 4'b1010},
        '{KIND_USUB, 64'h5, 64'h0, 6'd0, 1'b1, 64'h5, 4'b0010},
        '{KIND_INC,  ALL_ONES, 64'h0, 6'd0, 1'b1, 64'h0, 4'b1011},
        '{KIND_DEC,  64'h0, 64'h0, 6'd0, 1'b1, ALL_ONES, 4'b0010},
        '{KIND_SADD, MOST_NEG, MOST_NEG, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_SSUB, MOST_NEG, 64'h1, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_SSUB, MOST_POS, ALL_ONES, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_USUB, 64'h3, 64'h5, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_AND,  ALL_ONES, 64'h0f0f_0f0f_0f0f_0f0f, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_OR,   64'h0, 64'h0, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_XOR,  64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 6'd0, 1'b0,
          64'h0, 4'b0000},
        '{KIND_SAL,  64'h4000_0000_0000_0000, 64'h0, 6'd1, 1'b0, 64'h0, 4'b0000},
        '{KIND_SAL,  64'h1, 64'h0, 6'd63, 1'b0, 64'h0, 4'b0000},
        '{KIND_SAL,  64'hc000_0000_0000_0000, 64'h0, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_SAR,  MOST_NEG, 64'h0, 6'd63, 1'b0, 64'h0, 4'b0000},
        '{KIND_SAR,  MOST_POS, 64'h0, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_SHL,  ALL_ONES, 64'h0, 6'd63, 1'b0, 64'h0, 4'b0000},
        '{KIND_SHL,  64'h1234_5678_9abc_def0, 64'h0, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_SHR,  ALL_ONES, 64'h0, 6'd63, 1'b0, 64'h0, 4'b0000},
        '{KIND_SHR,  MOST_NEG, 64'h0, 6'd0, 1'b0, 64'h0, 4'b0000},
        '{KIND_NONE_LO, ALL_ONES, ALL_ONES, 6'd63, 1'b0, 64'h0, 4'b0000},
        '{KIND_NONE_HI, 64'h0, MOST_NEG, 6'd1, 1'b0, 64'h0, 4'b0000}
    };

    alu_with_condition_flags i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [DATA_W-1:0] signed_sum(logic [DATA_W-1:0] a,
                                                      logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        logic              a_pos;
        logic              b_pos;
        r = a + b;
        a_pos = !a[DATA_W-1] && a != '0;
        b_pos = !b[DATA_W-1] && b != '0;
        cc_flags.zero = (r == '0);
        cc_flags.sign = r[DATA_W-1];
        cc_flags.overflow = (a_pos && b_pos && r[DATA_W-1]) ||
                            (a[DATA_W-1] && b[DATA_W-1] && !r[DATA_W-1]);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] unsigned_sum(logic [DATA_W-1:0] a,
                                                        logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = a + b;
        cc_flags.zero = (r == '0);
        cc_flags.carry = (r < a) && (r < b);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] bitwise_done(logic [DATA_W-1:0] r);
        cc_flags.zero = (r == '0);
        cc_flags.sign = r[DATA_W-1];
        cc_flags.overflow = 1'b0;
        return r;
    endfunction

    function automatic alu_result_t alu_predict(logic [KIND_W-1:0] kind,
                                                logic [DATA_W-1:0] a,
                                                logic [DATA_W-1:0] b,
                                                logic [SHAMT_W-1:0] n);
        alu_result_t res;
        logic [DATA_W-1:0] r;
        logic              a_pos;
        case (kind)
            KIND_SADD: r = signed_sum(a, b);
            KIND_UADD: r = unsigned_sum(a, b);
            KIND_SSUB: r = signed_sum(a, DATA_W'(0) - b);
            KIND_USUB: r = unsigned_sum(a, DATA_W'(0) - b);
            KIND_INC:  r = unsigned_sum(a, DATA_W'(1));
            KIND_DEC:  r = unsigned_sum(a, ALL_ONES);
            KIND_AND:  r = bitwise_done(a & b);
            KIND_OR:   r = bitwise_done(a | b);
            KIND_XOR:  r = bitwise_done(a ^ b);
            KIND_SAL: begin
                a_pos = !a[DATA_W-1] && a != '0;
                r = a << n;
                cc_flags.zero = (r == '0);
                cc_flags.sign = r[DATA_W-1];
                cc_flags.overflow = (a[DATA_W-1] && !r[DATA_W-1]) || (a_pos && r[DATA_W-1]);
            end
            KIND_SAR:  r = bitwise_done(DATA_W'($signed(a) >>> n));
            KIND_SHL: begin
                r = a << n;
                cc_flags.zero = (r == '0);
                cc_flags.carry = (r < a);
            end
            KIND_SHR: begin
                r = a >> n;
                cc_flags.zero = (r == '0);
                cc_flags.carry = 1'b0;
            end
            default: r = '0;
        endcase
        res.value = r;
        res.flags = cc_flags;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_operand();
        logic [DATA_W-1:0] small_val;
        small_val = DATA_W'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DATA_W'(1);
            2: return ALL_ONES;
            3: return MOST_NEG;
            4: return MOST_POS;
            5: return small_val;
            6: return DATA_W'(0) - small_val;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit calm_window();
        return ops_accepted >= CALM_FROM && ops_accepted < CALM_TO;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_window() || roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(op_req_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        offered_ops.push_back(req);
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-2*DATA_W-SHAMT_W){1'b0}}, req.n, req.b, req.a};
        s_tuser <= req.kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_val,
                               logic [DATA_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %h, got %h", name, exp_val, act_val);
            failed = 1'b1;
        end
    endtask

    initial begin
        op_req_t req;
        while (!aresetn) @(posedge aclk);
        foreach (directed_ops[i]) begin
            send_request(directed_ops[i]);
        end
        for (int i = 0; i < RANDOM_OPS; i++) begin
            req = '0;
            if ($urandom_range(0, 99) < 4) begin
                req.kind = KIND_W'($urandom_range(KIND_NONE_LO, KIND_NONE_HI));
            end else begin
                req.kind = KIND_W'($urandom_range(KIND_SADD, KIND_SHR));
            end
            req.a = random_operand();
            req.b = random_operand();
            case ($urandom_range(0, 6))
                0: req.n = '0;
                1: req.n = '1;
                default: req.n = SHAMT_W'($urandom_range(0, 63));
            endcase
            send_request(req);
        end
        s_tvalid <= 1'b0;
        while (ops_accepted < DIRECTED_N + RANDOM_OPS || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // The receiver holds off once for a long stretch so that the block fills and
    // stalls its input.
    initial begin
        bit held;
        int stall;
        held = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held && ops_accepted >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (calm_window() || $urandom_range(0, 99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        op_req_t     req;
        alu_result_t res;
        alu_result_t exp_res;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                res = alu_predict(s_tuser, s_tdata[DATA_W-1:0],
                                  s_tdata[2*DATA_W-1:DATA_W],
                                  s_tdata[2*DATA_W+SHAMT_W-1:2*DATA_W]);
                if (offered_ops.size() != 0) begin
                    req = offered_ops.pop_front();
                    if (req.typed) begin
                        res.value = req.value;
                        res.flags = req.flags;
                    end
                end
                pending_results.push_back(res);
                ops_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result arrived with no request outstanding: value %h", m_tdata);
                    failed = 1'b1;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("value", exp_res.value, m_tdata);
                    check_field("zero_flag", DATA_W'(exp_res.flags.zero),
                                DATA_W'(m_tuser[0]));
                    check_field("sign_flag", DATA_W'(exp_res.flags.sign),
                                DATA_W'(m_tuser[1]));
                    check_field("overflow_flag", DATA_W'(exp_res.flags.overflow),
                                DATA_W'(m_tuser[2]));
                    check_field("carry_flag", DATA_W'(exp_res.flags.carry),
                                DATA_W'(m_tuser[3]));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $error("no request or result moved for %0d cycles", IDLE_LIMIT);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

endmodule
